>>> rtl/bbtt_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed bound transposition table: shared definitions
// Sizes, hash constants, request codes and the bucket row layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bbtt_pkg;

   localparam int IndexBits = 16;
   localparam int WayBits   = 2;
   localparam int Ways      = 1 << WayBits;
   localparam int RowBits   = IndexBits - WayBits;
   localparam int Rows      = 1 << RowBits;

   localparam int KeyBits   = 64;
   localparam int DepthBits = 8;
   localparam int BoundBits = 8;

   localparam int ReqDataBits = KeyBits + DepthBits + 2 * BoundBits;
   localparam int ReqUserBits = 1;
   localparam int RspDataBits = 2 * BoundBits;
   localparam int RspUserBits = 2;

   localparam int RspUserHit   = 0;
   localparam int RspUserEvict = 1;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_STORE  = 1'b1;

   localparam logic [63:0] HashKey   = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] HashMix   = 64'h632BE59BD9B4E019 * 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] HashDepth = 64'h94D049BB133111EB;
   localparam logic [63:0] HashFinal = 64'hBF58476D1CE4E5B9;
   localparam int          HashShift = 31;

   typedef struct packed {
      logic                 valid;
      logic [KeyBits-1:0]   key;
      logic [DepthBits-1:0] depth;
      logic [BoundBits-1:0] low;
      logic [BoundBits-1:0] high;
   } slot_type;

   typedef slot_type [Ways-1:0] row_type;

endpackage

`default_nettype wire

>>> rtl/bbtt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbtt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrBits = $clog2(Depth)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [Width-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [Width-1:0]    rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bucketed_bound_transposition_table_unit.sv
// ----------------------------------------------------------------------------
// Bucketed bound transposition table unit
// Hashed four-way table of lower/upper bound pairs keyed by key and depth.
// ----------------------------------------------------------------------------
// A request is a lookup or a store of a bound pair for a 64-bit key at an
// 8-bit depth. The table sits in one RAM of 16384 bucket rows, four slots a
// row. After reset the unit sweeps the RAM to clear every slot, one row a
// cycle, and takes no request until the sweep is done. Each request then
// hashes in the MUL1, MIX and MUL2 states on one shared bank of 32-bit
// partial-product multipliers (two 64-bit constant multiplies), reads the
// bucket row in LOOK, and in EVAL compares, merges or replaces, writes the
// row back on a store and registers the result. A new request is taken only
// once the unit is back in idle; a stalled result holds the next one in EVAL
// until it is taken. One request is in flight at a time; a new one is
// accepted while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_bound_transposition_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key, depth, low_bound, high_bound
   input  logic [bbtt_pkg::ReqDataBits-1:0]    req_tdata,
   // cmd
   input  logic [bbtt_pkg::ReqUserBits-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // found_low, found_high
   output logic [bbtt_pkg::RspDataBits-1:0]    rsp_tdata,
   // hit, evicted
   output logic [bbtt_pkg::RspUserBits-1:0]    rsp_tuser
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_MUL1  = 7'b0000100,
      ST_MIX   = 7'b0001000,
      ST_MUL2  = 7'b0010000,
      ST_LOOK  = 7'b0100000,
      ST_EVAL  = 7'b1000000
   } state_type;

   localparam int KB = bbtt_pkg::KeyBits;
   localparam int DB = bbtt_pkg::DepthBits;
   localparam int BB = bbtt_pkg::BoundBits;
   localparam int WB = bbtt_pkg::WayBits;

   state_type state_ff, state_in;
   logic [bbtt_pkg::RowBits-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [bbtt_pkg::RspDataBits-1:0] rsp_data_ff, rsp_data_in;
   logic [bbtt_pkg::RspUserBits-1:0] rsp_user_ff, rsp_user_in;

   logic          cmd_ff;
   logic [KB-1:0] key_ff;
   logic [DB-1:0] depth_ff;
   logic [BB-1:0] low_ff;
   logic [BB-1:0] high_ff;

   logic [63:0] pll_ff, pll_in;
   logic [31:0] pxa_ff, pxa_in;
   logic [31:0] pxb_ff, pxb_in;
   logic [39:0] dlo_ff, dlo_in;
   logic [31:0] dhi_ff, dhi_in;
   logic [63:0] mix_ff, mix_in;
   logic [bbtt_pkg::RowBits-1:0] row_ff, row_in;

   logic [63:0] mul_a, mul_b;
   logic [63:0] h0;
   logic [31:0] hash_top;
   logic [bbtt_pkg::IndexBits-1:0] index;
   logic accept, rsp_free, done;

   logic ram_wr_en;
   logic [bbtt_pkg::RowBits-1:0] ram_wr_addr;
   bbtt_pkg::row_type ram_wr_row, rd_row, new_row;
   logic ram_rd_en;

   logic hit;
   logic [WB-1:0] hit_way, vic_way;
   logic [BB-1:0] merge_low, merge_high;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign done     = (state_ff == ST_EVAL) && rsp_free;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MIX;
         ST_MIX:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_LOOK;
         ST_LOOK: state_in = ST_EVAL;
         ST_EVAL: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // shared multiplier bank: key multiply first, final multiply second
   always_comb begin
      if (state_ff == ST_MUL1) begin
         mul_a = key_ff;
         mul_b = bbtt_pkg::HashKey;
      end else begin
         mul_a = mix_ff;
         mul_b = bbtt_pkg::HashFinal;
      end
   end

   assign pll_in = {32'b0, mul_a[31:0]} * {32'b0, mul_b[31:0]};
   assign pxa_in = mul_a[63:32] * mul_b[31:0];
   assign pxb_in = mul_a[31:0] * mul_b[63:32];
   assign dlo_in = {32'b0, depth_ff} * {8'b0, bbtt_pkg::HashDepth[31:0]};
   assign dhi_in = {24'b0, depth_ff} * bbtt_pkg::HashDepth[63:32];

   assign hash_top = pll_ff[63:32] + pxa_ff + pxb_ff;
   assign h0 = {hash_top, pll_ff[31:0]} ^ bbtt_pkg::HashMix
             ^ ({dhi_ff, 32'b0} + {24'b0, dlo_ff});
   assign mix_in = h0 ^ (h0 >> bbtt_pkg::HashShift);

   assign index  = hash_top[31 -: bbtt_pkg::IndexBits];
   assign row_in = index[bbtt_pkg::IndexBits-1:WB];

   always_comb begin
      logic have;
      hit     = 1'b0;
      hit_way = '0;
      vic_way = '0;
      have    = 1'b0;
      for (int i = 0; i < bbtt_pkg::Ways; i++) begin
         if (!hit && rd_row[i].valid && rd_row[i].depth == depth_ff
             && rd_row[i].key == key_ff) begin
            hit     = 1'b1;
            hit_way = WB'(i);
         end
         if (!rd_row[i].valid) begin
            if (!have || rd_row[vic_way].valid) begin
               vic_way = WB'(i);
               have    = 1'b1;
            end
         end else if (!have || (rd_row[vic_way].valid
                                && rd_row[i].depth < rd_row[vic_way].depth)) begin
            vic_way = WB'(i);
            have    = 1'b1;
         end
      end
   end

   always_comb begin
      bbtt_pkg::slot_type cur;
      cur        = rd_row[hit_way];
      merge_low  = (low_ff > cur.low) ? low_ff : cur.low;
      merge_high = (high_ff < cur.high) ? high_ff : cur.high;
      new_row    = rd_row;
      rsp_user_in = '0;
      rsp_data_in = '0;
      rsp_user_in[bbtt_pkg::RspUserHit] = hit;
      if (hit) begin
         new_row[hit_way].low  = merge_low;
         new_row[hit_way].high = merge_high;
         if (cmd_ff == bbtt_pkg::CMD_STORE) begin
            rsp_data_in = {merge_high, merge_low};
         end else begin
            rsp_data_in = {cur.high, cur.low};
         end
      end else begin
         new_row[vic_way] = '{valid: 1'b1, key: key_ff, depth: depth_ff,
                              low: low_ff, high: high_ff};
         if (cmd_ff == bbtt_pkg::CMD_STORE) begin
            rsp_data_in = {high_ff, low_ff};
            rsp_user_in[bbtt_pkg::RspUserEvict] = rd_row[vic_way].valid;
         end
      end
   end

   always_comb begin
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign ram_wr_en   = (state_ff == ST_CLEAR) || (done && cmd_ff == bbtt_pkg::CMD_STORE);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : row_ff;
   assign ram_wr_row  = (state_ff == ST_CLEAR) ? '0 : new_row;
   assign ram_rd_en   = (state_ff == ST_LOOK);

   bbtt_ram #(
      .Width ($bits(bbtt_pkg::row_type)),
      .Depth (bbtt_pkg::Rows)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_row),
      .rd_en   (ram_rd_en),
      .rd_addr (row_in),
      .rd_data (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser[0];
         key_ff   <= req_tdata[KB-1:0];
         depth_ff <= req_tdata[KB+DB-1:KB];
         low_ff   <= req_tdata[KB+DB+BB-1:KB+DB];
         high_ff  <= req_tdata[KB+DB+2*BB-1:KB+DB+BB];
      end
      pll_ff <= pll_in;
      pxa_ff <= pxa_in;
      pxb_ff <= pxb_in;
      dlo_ff <= dlo_in;
      dhi_ff <= dhi_in;
      if (state_ff == ST_MIX) begin
         mix_ff <= mix_in;
      end
      if (state_ff == ST_LOOK) begin
         row_ff <= row_in;
      end
      if (done) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

>>> rtl/bbtt_checker.sv
// ----------------------------------------------------------------------------
// Bucketed bound transposition table: port checker
// Watches the unit's ports for reset, sequencing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module bbtt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bbtt_pkg::RspDataBits-1:0] rsp_tdata,
   input logic [bbtt_pkg::RspUserBits-1:0] rsp_tuser
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request or result port active after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[bbtt_pkg::RspUserHit] && rsp_tuser[bbtt_pkg::RspUserEvict]))
      else $error("eviction reported on a hit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind bucketed_bound_transposition_table_unit bbtt_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucketed bound transposition table unit: self-checking testbench
// Drives lookup and store requests over the request stream and checks every
// response against a predictor that keeps its own copy of the table. The
// directed part covers misses, merges, crossed bounds and replacement in a
// full bucket. The random part works mostly on keys crafted to fall into a
// few busy buckets, so hits, merges and evictions are frequent. Random idling
// and stalls are applied on both streams.
// ----------------------------------------------------------------------------

module tb_top;
   import bbtt_pkg::*;

   localparam int Slots        = 1 << IndexBits;
   localparam int HotBuckets   = 24;
   localparam int HotPerBucket = 7;
   localparam int RandomCount  = 1950;
   localparam int SettleCycles = 12;
   localparam int PrintLimit   = 100;

   typedef struct packed {
      logic                 cmd;
      logic [KeyBits-1:0]   key;
      logic [DepthBits-1:0] depth;
      logic [BoundBits-1:0] low;
      logic [BoundBits-1:0] high;
   } tt_request_type;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [BoundBits-1:0] found_low;
      logic [BoundBits-1:0] found_high;
   } tt_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata  = '0;
   logic [ReqUserBits-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic [RspUserBits-1:0] rsp_tuser;

   // table copy kept by the predictor
   bit                   tt_valid [Slots];
   logic [KeyBits-1:0]   tt_key   [Slots];
   logic [DepthBits-1:0] tt_depth [Slots];
   logic [BoundBits-1:0] tt_low   [Slots];
   logic [BoundBits-1:0] tt_high  [Slots];

   tt_request_type queued_requests [$];
   tt_result_type  expected_bounds [$];
   tt_request_type in_flight;
   int          accepted_count = 0;
   int          total_requests = 0;
   int          error_count    = 0;
   int          gap_left       = 0;
   int          stall_left     = 0;
   bit          send_calm      = 1'b0;
   bit          recv_calm      = 1'b0;

   logic [KeyBits-1:0]   hot_key   [HotBuckets*HotPerBucket];
   logic [DepthBits-1:0] hot_depth [HotBuckets*HotPerBucket];

   bucketed_bound_transposition_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [IndexBits-1:0] bucket_base_of(logic [KeyBits-1:0] key,
                                                           logic [DepthBits-1:0] depth);
      logic [63:0] h;
      logic [63:0] idx;
      h = (key * HashKey) ^ HashMix ^ ({56'd0, depth} * HashDepth);
      h = h ^ (h >> HashShift);
      h = h * HashFinal;
      idx = h >> (64 - IndexBits);
      return IndexBits'(idx - (idx % Ways));
   endfunction

   function automatic logic [63:0] odd_inverse(logic [63:0] c);
      logic [63:0] x;
      x = c;
      repeat (6) x = x * (64'd2 - c * x);
      return x;
   endfunction

   // invert the hash: pick the final product, then undo each step
   function automatic logic [KeyBits-1:0] key_in_bucket(logic [IndexBits-1:0] base,
                                                        logic [DepthBits-1:0] depth);
      logic [63:0] h;
      logic [IndexBits-1:0] idx;
      idx = base + IndexBits'($urandom_range(0, Ways - 1));
      h = {$urandom, $urandom};
      h[63 -: IndexBits] = idx;
      h = h * odd_inverse(HashFinal);
      h = h ^ (h >> HashShift) ^ (h >> (2 * HashShift));
      return (h ^ HashMix ^ ({56'd0, depth} * HashDepth)) * odd_inverse(HashKey);
   endfunction

   function automatic tt_result_type resolve_bounds(tt_request_type r);
      tt_result_type        res;
      logic [IndexBits-1:0] base;
      logic [IndexBits-1:0] s;
      logic [IndexBits-1:0] victim;
      bit                   have_victim;
      bit                   matched;
      res = '0;
      base = bucket_base_of(r.key, r.depth);
      victim = '0;
      have_victim = 1'b0;
      matched = 1'b0;
      for (int i = 0; i < Ways; i++) begin
         if (!matched) begin
            s = base + IndexBits'(i);
            if (tt_valid[s] && tt_depth[s] == r.depth && tt_key[s] == r.key) begin
               if (r.cmd == CMD_STORE) begin
                  if (r.low > tt_low[s]) tt_low[s] = r.low;
                  if (r.high < tt_high[s]) tt_high[s] = r.high;
               end
               matched = 1'b1;
               res.hit = 1'b1;
               res.found_low = tt_low[s];
               res.found_high = tt_high[s];
            end else if (!tt_valid[s]) begin
               if (!have_victim || tt_valid[victim]) begin
                  victim = s;
                  have_victim = 1'b1;
               end
            end else if (!have_victim ||
                         (tt_valid[victim] && tt_depth[s] < tt_depth[victim])) begin
               victim = s;
               have_victim = 1'b1;
            end
         end
      end
      if (!matched && r.cmd == CMD_STORE) begin
         res.evicted = tt_valid[victim];
         tt_valid[victim] = 1'b1;
         tt_key[victim] = r.key;
         tt_depth[victim] = r.depth;
         tt_low[victim] = r.low;
         tt_high[victim] = r.high;
         res.found_low = r.low;
         res.found_high = r.high;
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= PrintLimit)
         $display("MISMATCH at %0t: %s got %0h expected %0h", $time, field, got, want);
   endtask

   task automatic add_request(logic cmd, logic [KeyBits-1:0] key, logic [DepthBits-1:0] depth,
                              logic [BoundBits-1:0] low, logic [BoundBits-1:0] high);
      queued_requests.push_back('{cmd: cmd, key: key, depth: depth, low: low, high: high});
   endtask

   function automatic logic [BoundBits-1:0] pick_bound();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return BoundBits'($urandom);
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      tt_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_bounds.push_back(resolve_bounds(in_flight));
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               nxt = queued_requests.pop_front();
               in_flight <= nxt;
               req_tdata <= {nxt.high, nxt.low, nxt.depth, nxt.key};
               req_tuser <= nxt.cmd;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
               gap_left <= send_calm ? 0 : $urandom_range(0, 19);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_responses
      tt_result_type want;
      int            drawn;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_bounds.size() == 0) begin
            report_mismatch("unexpected response", 64'({rsp_tuser, rsp_tdata}), '0);
         end else begin
            want = expected_bounds.pop_front();
            if (rsp_tuser[RspUserHit] !== want.hit)
               report_mismatch("hit", 64'(rsp_tuser[RspUserHit]), 64'(want.hit));
            if (rsp_tuser[RspUserEvict] !== want.evicted)
               report_mismatch("evicted", 64'(rsp_tuser[RspUserEvict]), 64'(want.evicted));
            if (rsp_tdata[BoundBits-1:0] !== want.found_low)
               report_mismatch("found_low", 64'(rsp_tdata[BoundBits-1:0]),
                               64'(want.found_low));
            if (rsp_tdata[2*BoundBits-1:BoundBits] !== want.found_high)
               report_mismatch("found_high", 64'(rsp_tdata[2*BoundBits-1:BoundBits]),
                               64'(want.found_high));
         end
         if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
         drawn = recv_calm ? 0 : $urandom_range(0, 19);
         stall_left <= drawn;
         rsp_tready <= (drawn == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [IndexBits-1:0] base;
      logic [KeyBits-1:0]   fill_key [6];
      logic [DepthBits-1:0] fill_depth [6];
      logic [KeyBits-1:0]   ones;
      int                   pick;

      ones = '1;
      fill_depth = '{8'd5, 8'd3, 8'd7, 8'd3, 8'd9, 8'd2};
      base = IndexBits'($urandom_range(0, Rows - 1) * Ways);
      for (int i = 0; i < 6; i++) fill_key[i] = key_in_bucket(base, fill_depth[i]);

      // misses, merges and crossed bounds
      add_request(CMD_LOOKUP, '0, 8'd0, 8'hFF, 8'hFF);
      add_request(CMD_STORE, '0, 8'd0, 8'd0, 8'd255);
      add_request(CMD_LOOKUP, '0, 8'd0, 8'd0, 8'd0);
      add_request(CMD_STORE, '0, 8'd0, 8'd10, 8'd200);
      add_request(CMD_STORE, '0, 8'd0, 8'd5, 8'd250);
      add_request(CMD_STORE, ones, 8'd255, 8'd255, 8'd0);
      add_request(CMD_LOOKUP, ones, 8'd255, 8'd0, 8'd0);
      add_request(CMD_STORE, ones, 8'd255, 8'd0, 8'd255);
      add_request(CMD_LOOKUP, '0, 8'd1, 8'd0, 8'd0);
      add_request(CMD_LOOKUP, ones, 8'd254, 8'd0, 8'd0);
      // fill one bucket, then replace by smallest depth, first slot on a tie
      for (int i = 0; i < 4; i++)
         add_request(CMD_STORE, fill_key[i], fill_depth[i], 8'(i + 1), 8'(100 + i));
      add_request(CMD_STORE, fill_key[4], fill_depth[4], 8'd20, 8'd120);
      add_request(CMD_LOOKUP, fill_key[1], fill_depth[1], 8'd0, 8'd0);
      add_request(CMD_LOOKUP, fill_key[4], fill_depth[4], 8'd0, 8'd0);
      add_request(CMD_STORE, fill_key[5], fill_depth[5], 8'd30, 8'd130);
      add_request(CMD_LOOKUP, fill_key[3], fill_depth[3], 8'd0, 8'd0);
      add_request(CMD_STORE, fill_key[0], fill_depth[0], 8'd50, 8'd60);
      add_request(CMD_STORE, fill_key[1], fill_depth[1], 8'd7, 8'd77);
      add_request(CMD_LOOKUP, fill_key[5], fill_depth[5], 8'd0, 8'd0);

      for (int b = 0; b < HotBuckets; b++) begin
         base = IndexBits'($urandom_range(0, Rows - 1) * Ways);
         for (int k = 0; k < HotPerBucket; k++) begin
            pick = b * HotPerBucket + k;
            hot_depth[pick] = ($urandom_range(0, 3) == 0) ? DepthBits'($urandom_range(0, 3))
                                                          : DepthBits'($urandom);
            hot_key[pick] = key_in_bucket(base, hot_depth[pick]);
         end
      end

      for (int n = 0; n < RandomCount; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, HotBuckets * HotPerBucket - 1);
            add_request($urandom_range(0, 1) ? CMD_STORE : CMD_LOOKUP, hot_key[pick],
                        hot_depth[pick], pick_bound(), pick_bound());
         end else begin
            add_request($urandom_range(0, 1) ? CMD_STORE : CMD_LOOKUP, {$urandom, $urandom},
                        DepthBits'($urandom), pick_bound(), pick_bound());
         end
      end
      total_requests = queued_requests.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(accepted_count == total_requests && expected_bounds.size() == 0))
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/bbtt_pkg.sv
rtl/bbtt_ram.sv
rtl/bucketed_bound_transposition_table_unit.sv
rtl/bbtt_checker.sv
tb/sv/tb_top.sv
